### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/oaids_pkg.sv
// ----------------------------------------------------------------------------
// oaids_pkg
// Types, codes and sizes shared by the ordered array list block.
// ----------------------------------------------------------------------------
package oaids_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DEL_AT  = 3'd1,
    ACT_DEL_VAL = 3'd2,
    ACT_FIND    = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic [IDX_W-1:0]         match_index;
    logic [CNT_W-1:0]         removed;
    logic [CNT_W-1:0]         entry_count;
    logic signed [DATA_W-1:0] read_value;
  } out_t;

endpackage

### hw/rtl/ordered_array_insert_delete_search_top.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search_top
// Packed list of signed values with insert, delete, search and read actions.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the in_ channel carries one action, a position
// and a value. Exactly one result transaction leaves on the out_ channel for
// every input transaction, in order. The list lives in a single memory with
// one write port and one registered read port, and the entry count in a
// register. Insert and delete-at move entries one per cycle through that
// memory, delete-by-value compacts the list in one pass, and find scans from
// index zero until the first match; errors and unused codes read nothing.
// The read port, one entry per cycle, sets the pace of every walk. One action
// is in work at a time: in_ready is high only while the block is idle, which
// is from the cycle in which the result is first offered.
// Reset clears the count, so the list is empty afterwards; the memory itself
// is not cleared, since only entries below the count are ever read.
// A result waits in the output register while out_ready is low; the block
// still takes and works on the next transaction, and holds that one back
// only when it is finished and the output register is still occupied.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_search_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  oaids_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output oaids_pkg::out_t  out_data
);

  localparam int DEPTH  = oaids_pkg::DEPTH;
  localparam int DATA_W = oaids_pkg::DATA_W;
  localparam int IDX_W  = oaids_pkg::IDX_W;
  localparam int CNT_W  = oaids_pkg::CNT_W;
  localparam int ACT_W  = oaids_pkg::ACT_W;

  // List storage: one write and one registered read per cycle.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Control and working registers.
  oaids_pkg::state_t  state_r, state_nxt;
  logic [ACT_W-1:0]   op_r, op_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  logic               dir_dn_r, dir_dn_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   keep_r, keep_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   match_r, match_nxt;
  logic [DATA_W-1:0]  rdval_r, rdval_nxt;
  oaids_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0]   removed_r, removed_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  oaids_pkg::out_t    out_data_r, out_data_nxt;

  assign rd_addr   = ptr_r[IDX_W-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    dir_dn_nxt    = dir_dn_r;
    keep_nxt      = keep_r;
    found_nxt     = found_r;
    match_nxt     = match_r;
    rdval_nxt     = rdval_r;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      oaids_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Latch the transaction and set up the walk through the memory.
          op_nxt      = in_data.action;
          pos_nxt     = in_data.position;
          val_nxt     = in_data.value;
          keep_nxt    = '0;
          found_nxt   = 1'b0;
          match_nxt   = '0;
          rdval_nxt   = '0;
          removed_nxt = '0;
          status_nxt  = oaids_pkg::ST_OK;
          left_nxt    = '0;
          ptr_nxt     = '0;
          dir_dn_nxt  = 1'b0;
          state_nxt   = oaids_pkg::S_SCAN;
          unique case (in_data.action)
            oaids_pkg::ACT_INSERT: begin
              // Fullness is checked before the position.
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = oaids_pkg::ST_FULL;
              end else if (in_data.position > count_r) begin
                status_nxt = oaids_pkg::ST_RANGE;
              end else begin
                // Move entries up, starting at the top of the list.
                left_nxt   = count_r - in_data.position;
                ptr_nxt    = count_r - CNT_W'(1);
                dir_dn_nxt = 1'b1;
              end
            end
            oaids_pkg::ACT_DEL_AT: begin
              if (in_data.position >= count_r) begin
                status_nxt = oaids_pkg::ST_RANGE;
              end else begin
                left_nxt = count_r - in_data.position - CNT_W'(1);
                ptr_nxt  = in_data.position + CNT_W'(1);
              end
            end
            oaids_pkg::ACT_DEL_VAL,
            oaids_pkg::ACT_FIND: begin
              left_nxt = count_r;
            end
            oaids_pkg::ACT_READ: begin
              if (in_data.position >= count_r) begin
                status_nxt = oaids_pkg::ST_RANGE;
              end else begin
                left_nxt = CNT_W'(1);
                ptr_nxt  = in_data.position;
              end
            end
            default: ;
          endcase
        end
      end

      oaids_pkg::S_SCAN: begin
        // Issue one read per cycle.
        if (left_r != '0) begin
          rd_en    = 1'b1;
          left_nxt = left_r - CNT_W'(1);
          ptr_nxt  = dir_dn_r ? ptr_r - CNT_W'(1) : ptr_r + CNT_W'(1);
        end

        // Handle the entry read in the previous cycle. Writes always land on
        // an index that is never read again in this pass.
        if (rd_vld_r) begin
          unique case (op_r)
            oaids_pkg::ACT_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = rd_idx_r + IDX_W'(1);
              wr_data = rd_data_r;
            end
            oaids_pkg::ACT_DEL_AT: begin
              wr_en   = 1'b1;
              wr_addr = rd_idx_r - IDX_W'(1);
              wr_data = rd_data_r;
            end
            oaids_pkg::ACT_DEL_VAL: begin
              if (rd_data_r != val_r) begin
                wr_en    = 1'b1;
                wr_addr  = keep_r[IDX_W-1:0];
                wr_data  = rd_data_r;
                keep_nxt = keep_r + CNT_W'(1);
              end
            end
            oaids_pkg::ACT_FIND: begin
              // Stop at the first match; a read already in flight is ignored.
              if (!found_r && rd_data_r == val_r) begin
                found_nxt = 1'b1;
                match_nxt = rd_idx_r;
                left_nxt  = '0;
              end
            end
            oaids_pkg::ACT_READ: begin
              rdval_nxt = rd_data_r;
            end
            default: ;
          endcase
        end

        // Walk finished: place an inserted value and settle the count.
        if (left_r == '0 && !rd_vld_r) begin
          state_nxt = oaids_pkg::S_RESULT;
          if (status_r == oaids_pkg::ST_OK) begin
            unique case (op_r)
              oaids_pkg::ACT_INSERT: begin
                wr_en     = 1'b1;
                wr_addr   = pos_r[IDX_W-1:0];
                wr_data   = val_r;
                count_nxt = count_r + CNT_W'(1);
              end
              oaids_pkg::ACT_DEL_AT: begin
                count_nxt   = count_r - CNT_W'(1);
                removed_nxt = CNT_W'(1);
              end
              oaids_pkg::ACT_DEL_VAL: begin
                count_nxt   = keep_r;
                removed_nxt = count_r - keep_r;
              end
              default: ;
            endcase
          end
        end
      end

      oaids_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status      = status_r;
          out_data_nxt.found       = found_r;
          out_data_nxt.match_index = match_r;
          out_data_nxt.removed     = removed_r;
          out_data_nxt.entry_count = count_r;
          out_data_nxt.read_value  = rdval_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = oaids_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = oaids_pkg::S_IDLE;
      end
    endcase

    rd_vld_nxt = rd_en;
    rd_idx_nxt = rd_en ? rd_addr : rd_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oaids_pkg::S_IDLE;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    left_r     <= left_nxt;
    dir_dn_r   <= dir_dn_nxt;
    rd_idx_r   <= rd_idx_nxt;
    keep_r     <= keep_nxt;
    found_r    <= found_nxt;
    match_r    <= match_nxt;
    rdval_r    <= rdval_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hw/rtl/oaids_checker.sv
// ----------------------------------------------------------------------------
// oaids_checker
// Port-level checks for the ordered array list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oaids_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  oaids_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  oaids_pkg::out_t out_data
);

  // A result that is not taken stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // One action at a time: after a transaction is taken the input closes.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

  // The count never passes the list size.
  `ASSERT_CLK(a_count_bound, clk, rst_n, !out_valid || out_data.entry_count <= oaids_pkg::DEPTH, "entry count above depth")

  // A find hit is a clean result that removes nothing.
  `ASSERT_CLK(a_found_clean, clk, rst_n, !(out_valid && out_data.found) || (out_data.status == oaids_pkg::ST_OK && out_data.removed == '0 && out_data.read_value == '0), "find result carries other fields")

endmodule

bind ordered_array_insert_delete_search_top oaids_checker u_oaids_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
